// File: rtl/core/ial_pkg.sv
// ial_pkg: shared types and constants for the indexed array list unit.
// Operation codes, fixed field widths and parameter defaults.
// No dependencies.
package ial_pkg;

    localparam int CAPACITY_DEF  = 8;
    localparam int WORD_BITS_DEF = 32;

    localparam int POS_BITS   = 3;
    localparam int VALUE_BITS = 32;
    localparam int LEN_BITS   = 4;
    localparam int OP_BITS    = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SET    = 2'd2,
        OP_GET    = 2'd3
    } op_t;

endpackage

// File: rtl/core/ial_mem.sv
// ial_mem: entry storage, one write port and one read port,
// read data registered. Depends on nothing.
module ial_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ial_ctrl.sv
// ial_ctrl: sequencer for the list operations and the result register.
// Drives the entry memory (ial_mem) one entry per cycle; uses ial_pkg.
module ial_ctrl #(
    parameter int CAPACITY  = ial_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ial_pkg::WORD_BITS_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // request side
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  ial_pkg::op_t                          req_op,
    input  logic [ial_pkg::POS_BITS-1:0]          req_position,
    input  logic signed [ial_pkg::VALUE_BITS-1:0] req_value,
    // result side
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic                                  res_ok,
    output logic signed [ial_pkg::VALUE_BITS-1:0] res_read_value,
    output logic [ial_pkg::LEN_BITS-1:0]          res_list_length,
    // memory port
    output logic                                  mem_we,
    output logic [AW-1:0]                         mem_waddr,
    output logic [WORD_BITS-1:0]                  mem_wdata,
    output logic                                  mem_re,
    output logic [AW-1:0]                         mem_raddr,
    input  logic [WORD_BITS-1:0]                  mem_rdata
);
    import ial_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_BITS) ? CW : POS_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_FILL,
        S_GET,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [WORD_BITS-1:0]   val_reg, val_next;
    logic [AW-1:0]          src_reg, src_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ok_reg, ok_next;
    logic [VALUE_BITS-1:0]  rd_reg, rd_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_ok_reg, m_ok_next;
    logic [VALUE_BITS-1:0]  m_rd_reg, m_rd_next;
    logic [LEN_BITS-1:0]    m_len_reg, m_len_next;

    logic [CMP_W-1:0]       pos_c, cnt_c, cap_c;
    logic [AW-1:0]          pos_a;
    logic [WORD_BITS-1:0]   val_w;
    logic                   hit, ins_ok;

    assign pos_c  = CMP_W'(req_position);
    assign cnt_c  = CMP_W'(count_reg);
    assign cap_c  = CMP_W'(CAPACITY);
    assign pos_a  = AW'(pos_c);
    assign val_w  = WORD_BITS'(req_value);
    assign hit    = pos_c < cnt_c;
    assign ins_ok = (pos_c < cap_c) && (pos_c <= cnt_c) && (cnt_c < cap_c);

    assign req_ready = (state_reg == S_IDLE);

    // Shifts move one entry per cycle: the read issued in one cycle is written
    // back to its neighbor in the next, while the following read goes out on
    // the far side, so a write never meets a read of the same entry.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        src_next     = src_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        ok_next      = ok_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_rd_next    = m_rd_reg;
        m_len_next   = m_len_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = val_reg;
        mem_re       = 1'b0;
        mem_raddr    = src_reg;

        if (res_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    op_next    = req_op;
                    pos_next   = pos_a;
                    val_next   = val_w;
                    ok_next    = 1'b0;
                    rd_next    = '0;
                    state_next = S_DONE;
                    case (req_op)
                        OP_INSERT: begin
                            if (ins_ok) begin
                                ok_next    = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (pos_c == cnt_c) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = pos_a;
                                    mem_wdata = val_w;
                                end else begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = AW'(count_reg - CW'(1));
                                    src_next   = AW'(count_reg - CW'(1));
                                    rem_next   = CW'(cnt_c - pos_c - CMP_W'(1));
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        OP_DELETE: begin
                            if (hit) begin
                                ok_next    = 1'b1;
                                count_next = count_reg - CW'(1);
                                if ((cnt_c - pos_c) != CMP_W'(1)) begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = pos_a + AW'(1);
                                    src_next   = pos_a + AW'(1);
                                    rem_next   = CW'(cnt_c - pos_c - CMP_W'(2));
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        OP_SET: begin
                            if (hit) begin
                                ok_next   = 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = pos_a;
                                mem_wdata = val_w;
                            end
                        end
                        OP_GET: begin
                            if (hit) begin
                                ok_next    = 1'b1;
                                mem_re     = 1'b1;
                                mem_raddr  = pos_a;
                                state_next = S_GET;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                mem_waddr = (op_reg == OP_INSERT) ? src_reg + AW'(1) : src_reg - AW'(1);
                if (rem_reg != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = (op_reg == OP_INSERT) ? src_reg - AW'(1)
                                                      : src_reg + AW'(1);
                    src_next  = mem_raddr;
                    rem_next  = rem_reg - CW'(1);
                end else begin
                    state_next = (op_reg == OP_INSERT) ? S_FILL : S_DONE;
                end
            end
            S_FILL: begin
                // drop the new word into the gap left by the shift
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                state_next = S_DONE;
            end
            S_GET: begin
                rd_next    = VALUE_BITS'($signed(mem_rdata));
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || res_ready) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = ok_reg;
                    m_rd_next    = rd_reg;
                    m_len_next   = LEN_BITS'(count_reg);
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        src_reg   <= src_next;
        rem_reg   <= rem_next;
        ok_reg    <= ok_next;
        rd_reg    <= rd_next;
        m_ok_reg  <= m_ok_next;
        m_rd_reg  <= m_rd_next;
        m_len_reg <= m_len_next;
    end

    assign res_valid       = m_valid_reg;
    assign res_ok          = m_ok_reg;
    assign res_read_value  = m_rd_reg;
    assign res_list_length = m_len_reg;

endmodule

// File: rtl/core/indexed_array_list_unit.sv
// indexed_array_list_unit: top level of the fixed-capacity ordered list.
// Instantiates ial_ctrl and ial_mem; uses ial_pkg.
//
// Channel   Dir  Handshake         Payload
// s_ (req)  in   s_tvalid/tready   tuser: op; tdata: position, value
// m_ (res)  out  m_tvalid/tready   tuser: ok; tdata: read_value, list_length
//
// One request at a time. Set, get, a failed request and insert at the end move
// no entries; insert and delete at position p shift the entries from p to the
// end, one entry moved per cycle through the single memory write port. A new
// request is taken while the last result still waits. Reset empties the list;
// a stalled m_ side holds the next request in its final cycle.
module indexed_array_list_unit #(
    parameter int CAPACITY  = ial_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ial_pkg::WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [2:0] position, [34:3] value, [39:35] zero
    input  logic [1:0]  s_tuser,  // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] read_value, [35:32] list_length, [39:36] zero
    output logic [0:0]  m_tuser   // [0] ok
);
    import ial_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [WORD_BITS-1:0]         mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [WORD_BITS-1:0]         mem_rdata;
    logic                         res_ok;
    logic signed [VALUE_BITS-1:0] res_read_value;
    logic [LEN_BITS-1:0]          res_list_length;

    ial_ctrl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_op          (op_t'(s_tuser)),
        .req_position    (s_tdata[2:0]),
        .req_value       (s_tdata[34:3]),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res_ok          (res_ok),
        .res_read_value  (res_read_value),
        .res_list_length (res_list_length),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    ial_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata = {4'b0, res_list_length, res_read_value};
    assign m_tuser = res_ok;

endmodule

// File: rtl/core/ial_checker.sv
// ial_checker: port-level checks for indexed_array_list_unit, bound below.
// Uses ial_pkg for the capacity default.
module ial_checker #(
    parameter int CAPACITY = ial_pkg::CAPACITY_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result must hold
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("failed request returned a nonzero read value");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CAPACITY > 15) || (m_tdata[35:32] <= CAPACITY))
        else $error("list length above capacity");

    a_reset_idle: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid && s_tready)
        else $error("unit not idle after reset");

endmodule

bind indexed_array_list_unit ial_checker #(.CAPACITY(CAPACITY)) u_ial_checker (.*);

// File: bench/indexed_array_list_unit_test.sv
// indexed_array_list_unit_test: self-checking bench for the ordered list unit.
// Keeps a shadow copy of the list and checks every reply field by field.
// Depends on ial_pkg and indexed_array_list_unit.
module indexed_array_list_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ial_pkg::*;

    localparam int LIST_CAP   = CAPACITY_DEF;
    localparam int SETTLE_CYC = LIST_CAP + 12;

    typedef struct {
        logic                  ok;
        logic [VALUE_BITS-1:0] read_value;
        logic [LEN_BITS-1:0]   list_length;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_GET;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;

    // shadow of the list contents
    logic [VALUE_BITS-1:0] shadow_words [LIST_CAP];
    int                    shadow_count = 0;
    reply_t                pending_replies [$];
    int                    fail_count = 0;

    // receiver state
    bit no_idle = 1'b0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    indexed_array_list_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Apply one request to the shadow list and return the reply it should give.
    function automatic reply_t apply_list_op(op_t op, logic [POS_BITS-1:0] pos,
                                             logic [VALUE_BITS-1:0] word);
        reply_t rep;
        rep.ok = 1'b0;
        rep.read_value = '0;
        case (op)
            OP_INSERT: begin
                if (pos <= shadow_count && shadow_count < LIST_CAP) begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = word;
                    shadow_count++;
                    rep.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (pos < shadow_count) begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                    rep.ok = 1'b1;
                end
            end
            OP_SET: begin
                if (pos < shadow_count) begin
                    shadow_words[pos] = word;
                    rep.ok = 1'b1;
                end
            end
            default: begin
                if (pos < shadow_count) begin
                    rep.read_value = shadow_words[pos];
                    rep.ok = 1'b1;
                end
            end
        endcase
        rep.list_length = shadow_count[LEN_BITS-1:0];
        return rep;
    endfunction

    // Offer one request after a random gap; predict its reply once taken.
    task automatic send_request(input op_t op, input logic [POS_BITS-1:0] pos,
                                input logic [VALUE_BITS-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, word, pos};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_replies.push_back(apply_list_op(op, pos, word));
    endtask

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(negedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("reply with no request outstanding: ok=%0d data=%h",
                       m_tuser[0], m_tdata);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tuser[0] !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, m_tuser[0]);
                    fail_count++;
                end
                if (m_tdata[31:0] !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(want.read_value), $signed(m_tdata[31:0]));
                    fail_count++;
                end
                if (m_tdata[35:32] !== want.list_length) begin
                    $error("list_length: expected %0d, got %0d",
                           want.list_length, m_tdata[35:32]);
                    fail_count++;
                end
            end
        end
    end

    // Requests that must fail on an empty list: get, delete, set and insert past the end.
    task automatic test_empty_list();
        send_request(OP_GET, 3'd0, 32'h0);
        send_request(OP_DELETE, 3'd0, 32'h0);
        send_request(OP_SET, 3'd0, 32'h1234_5678);
        send_request(OP_INSERT, 3'd1, 32'h5555_5555);
        send_request(OP_GET, 3'd7, 32'h0);
        send_request(OP_INSERT, 3'd7, 32'hAAAA_AAAA);
    endtask

    // Fill at the front, the back and the middle, then push past capacity.
    task automatic test_fill_and_overflow();
        send_request(OP_INSERT, 3'd0, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 3'd1, 32'h8000_0000);
        send_request(OP_INSERT, 3'd1, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 3'd0, 32'h0000_0000);
        send_request(OP_INSERT, 3'd4, 32'h0000_0001);
        send_request(OP_INSERT, 3'd5, 32'hDEAD_BEEF);
        send_request(OP_INSERT, 3'd3, 32'h1357_9BDF);
        send_request(OP_INSERT, 3'd7, 32'h2468_ACE0);
        send_request(OP_INSERT, 3'd7, 32'h0F0F_0F0F);
        send_request(OP_INSERT, 3'd0, 32'hF0F0_F0F0);
    endtask

    task automatic test_edit_values();
        send_request(OP_SET, 3'd7, 32'h8000_0000);
        send_request(OP_SET, 3'd0, 32'h7FFF_FFFF);
        send_request(OP_GET, 3'd0, 32'hFFFF_FFFF);
        send_request(OP_GET, 3'd7, 32'h0);
        send_request(OP_GET, 3'd3, 32'h0);
    endtask

    // Delete the last, first and a middle entry; read past the new end.
    task automatic test_drain();
        send_request(OP_DELETE, 3'd7, 32'h0);
        send_request(OP_DELETE, 3'd0, 32'h0);
        send_request(OP_GET, 3'd6, 32'h0);
        send_request(OP_DELETE, 3'd2, 32'h0);
    endtask

    // Hold the reply side for a long stretch while requests keep coming.
    task automatic test_reply_stall();
        no_idle = 1'b1;
        hold_requests++;
        for (int i = 0; i < 16; i++)
            send_request((i % 3 == 0) ? OP_INSERT : OP_GET,
                         POS_BITS'($urandom_range(0, 7)), $urandom);
        no_idle = 1'b0;
    endtask

    // Sweep the list between empty and full, mostly with in-range positions.
    task automatic test_random_ops(input int n_items);
        bit growing;
        int r;
        op_t op;
        logic [POS_BITS-1:0] pos;
        growing = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 4) == 0);
            if (shadow_count == LIST_CAP)
                growing = 1'b0;
            else if (shadow_count == 0)
                growing = 1'b1;
            r = $urandom_range(0, 99);
            if (r < (growing ? 50 : 15))
                op = OP_INSERT;
            else if (r < 65)
                op = OP_DELETE;
            else if (r < 80)
                op = OP_SET;
            else
                op = OP_GET;
            if ($urandom_range(0, 9) == 0)
                pos = POS_BITS'($urandom_range(0, 7));
            else if (op == OP_INSERT)
                pos = POS_BITS'($urandom_range(0, (shadow_count < 7) ? shadow_count : 7));
            else if (shadow_count > 0)
                pos = POS_BITS'($urandom_range(0, shadow_count - 1));
            else
                pos = POS_BITS'($urandom_range(0, 7));
            send_request(op, pos, $urandom);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_fill_and_overflow();
        test_edit_values();
        test_drain();
        test_reply_stall();
        test_random_ops(1900);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
